// ===== hdl/i2c_dac_write_master_core_macros.svh =====
// ----------------------------------------------------------------------------
// I2C DAC write master - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_DAC_WRITE_MASTER_CORE_MACROS_SVH
`define I2C_DAC_WRITE_MASTER_CORE_MACROS_SVH

// Same-cycle implication
`define I2CDAC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("i2cdac same-cycle check failed");

// Next-cycle implication
`define I2CDAC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("i2cdac next-cycle check failed");

`endif

// ===== hdl/i2cdac_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C DAC write master - package
// Transaction types, bus phase encoding, status codes and register indexes.
// ----------------------------------------------------------------------------
package i2cdac_pkg;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 7;
	localparam logic [CFG_INDEX_W-1:0] CFG_BUS_ENABLED    = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ADDRESS = 1'd1;

	localparam logic [6:0]  DEV_ADDR_RESET = 7'd12;
	localparam logic [15:0] CODE_MAX       = 16'd4095;
	localparam logic [7:0]  CMD_WRITE_UPD  = 8'h30;

	// Completion status
	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_REJECT = 2'd1;
	localparam logic [1:0] STATUS_NACK   = 2'd2;

	// Request operations
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Bus phases, one per tick
	typedef enum logic [3:0] {
		PH_IDLE       = 4'd0,
		PH_START1     = 4'd1,
		PH_START2     = 4'd2,
		PH_START3     = 4'd3,
		PH_BIT_DATA   = 4'd4,
		PH_BIT_HIGH   = 4'd5,
		PH_BIT_LOW    = 4'd6,
		PH_ACK_REL    = 4'd7,
		PH_ACK_HIGH   = 4'd8,
		PH_ACK_SAMPLE = 4'd9,
		PH_STOP1      = 4'd10,
		PH_STOP2      = 4'd11,
		PH_STOP3      = 4'd12
	} phase_t;

	typedef struct packed {
		logic        operation;
		logic [2:0]  channel;
		logic [15:0] code;
		logic        sda_in;
	} req_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_out;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [1:0] status;
	} res_t;

endpackage

// ===== hdl/i2cdac_stream_if.sv =====
// ----------------------------------------------------------------------------
// I2C DAC write master - stream channel
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface i2cdac_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/i2cdac_engine.sv =====
// ----------------------------------------------------------------------------
// I2C DAC write master - bus engine
// Holds the bus phase, shift and data state; advances one phase per step.
// ----------------------------------------------------------------------------
`include "i2c_dac_write_master_core_macros.svh"

module i2cdac_engine
	import i2cdac_pkg::*;
#(
	parameter int NUM_CHANNELS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step_en,
	input  req_t       req,
	input  logic       bus_enabled,
	input  logic [6:0] device_address,
	output res_t       res
);

	phase_t      phase_q, phase_n, phase_adv;
	logic [2:0]  bit_q, bit_n;
	logic [1:0]  byte_q, byte_n;
	logic [7:0]  shift_q, shift_n;
	logic [15:0] data_q, data_n;
	logic [7:0]  cmd_q, cmd_n;
	logic        nack_q, nack_n;
	logic        scl_q, sda_q, drv_q;
	logic        scl_d, sda_d, drv_d;
	logic        drive_pins;
	logic        done_c;
	logic [1:0]  status_c;
	logic [11:0] code_clamped;
	logic [7:0]  next_byte;

	// Clamp the requested code
	assign code_clamped = (req.code > CODE_MAX) ? CODE_MAX[11:0] : req.code[11:0];

	// Select the byte that follows the one just acknowledged
	always_comb begin
		unique case (byte_q)
			2'd0:    next_byte = cmd_q;
			2'd1:    next_byte = data_q[15:8];
			default: next_byte = data_q[7:0];
		endcase
	end

	// Next state
	always_comb begin
		phase_n    = phase_q;
		phase_adv  = phase_q;
		bit_n      = bit_q;
		byte_n     = byte_q;
		shift_n    = shift_q;
		data_n     = data_q;
		cmd_n      = cmd_q;
		nack_n     = nack_q;
		drive_pins = 1'b0;
		done_c     = 1'b0;
		status_c   = STATUS_OK;
		if (step_en) begin
			if (phase_q != PH_IDLE) begin
				drive_pins = 1'b1;
				unique case (phase_q)
					PH_START1:   phase_adv = PH_START2;
					PH_START2:   phase_adv = PH_START3;
					PH_START3: begin
						byte_n    = 2'd0;
						shift_n   = {device_address, 1'b0};
						bit_n     = 3'd7;
						phase_adv = PH_BIT_DATA;
					end
					PH_BIT_DATA: phase_adv = PH_BIT_HIGH;
					PH_BIT_HIGH: phase_adv = PH_BIT_LOW;
					PH_BIT_LOW: begin
						if (bit_q == 3'd0) begin
							phase_adv = PH_ACK_REL;
						end else begin
							bit_n     = bit_q - 3'd1;
							shift_n   = {shift_q[6:0], 1'b0};
							phase_adv = PH_BIT_DATA;
						end
					end
					PH_ACK_REL:  phase_adv = PH_ACK_HIGH;
					PH_ACK_HIGH: phase_adv = PH_ACK_SAMPLE;
					PH_ACK_SAMPLE: begin
						if (nack_q || byte_q == 2'd3) begin
							phase_adv = PH_STOP1;
						end else begin
							byte_n    = byte_q + 2'd1;
							shift_n   = next_byte;
							bit_n     = 3'd7;
							phase_adv = PH_BIT_DATA;
						end
					end
					PH_STOP1:    phase_adv = PH_STOP2;
					PH_STOP2:    phase_adv = PH_STOP3;
					default: begin
						phase_adv  = PH_IDLE;
						drive_pins = 1'b0;
					end
				endcase
				// Sample the acknowledge as SDA is released
				if (phase_adv == PH_ACK_SAMPLE && req.sda_in) begin
					nack_n = 1'b1;
				end
				if (phase_adv == PH_STOP3) begin
					done_c   = 1'b1;
					status_c = nack_q ? STATUS_NACK : STATUS_OK;
					phase_n  = PH_IDLE;
				end else begin
					phase_n = phase_adv;
				end
			end else if (req.operation == OP_WRITE) begin
				if (!bus_enabled || req.channel >= 3'(NUM_CHANNELS)) begin
					done_c   = 1'b1;
					status_c = STATUS_REJECT;
				end else begin
					data_n     = {code_clamped, 4'b0000};
					cmd_n      = CMD_WRITE_UPD | (8'd1 << req.channel[1:0]);
					nack_n     = 1'b0;
					bit_n      = 3'd0;
					byte_n     = 2'd0;
					shift_n    = 8'd0;
					phase_adv  = PH_START1;
					phase_n    = PH_START1;
					drive_pins = 1'b1;
				end
			end
		end
	end

	// Outputs: pin levels of the phase entered, plus completion
	always_comb begin
		scl_d = 1'b1;
		sda_d = 1'b1;
		drv_d = 1'b1;
		unique case (phase_adv)
			PH_START2:     begin scl_d = 1'b1; sda_d = 1'b0;       end
			PH_START3:     begin scl_d = 1'b0; sda_d = 1'b0;       end
			PH_BIT_DATA:   begin scl_d = 1'b0; sda_d = shift_n[7]; end
			PH_BIT_HIGH:   begin scl_d = 1'b1; sda_d = shift_n[7]; end
			PH_BIT_LOW:    begin scl_d = 1'b0; sda_d = shift_n[7]; end
			PH_ACK_REL:    begin scl_d = 1'b0; sda_d = 1'b1;       end
			PH_ACK_HIGH:   begin scl_d = 1'b1; sda_d = 1'b1;       end
			PH_ACK_SAMPLE: begin scl_d = 1'b0; sda_d = 1'b1; drv_d = 1'b0; end
			PH_STOP1:      begin scl_d = 1'b0; sda_d = 1'b0;       end
			PH_STOP2:      begin scl_d = 1'b1; sda_d = 1'b0;       end
			default:       begin scl_d = 1'b1; sda_d = 1'b1;       end
		endcase
		res.scl_level = drive_pins ? scl_d : scl_q;
		res.sda_out   = drive_pins ? sda_d : sda_q;
		res.sda_drive = drive_pins ? drv_d : drv_q;
		res.busy_res  = (phase_n != PH_IDLE);
		res.done_res  = done_c;
		res.status    = status_c;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bit_q   <= '0;
			byte_q  <= '0;
			shift_q <= '0;
			data_q  <= '0;
			cmd_q   <= '0;
			nack_q  <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			drv_q   <= 1'b1;
		end else if (step_en) begin
			phase_q <= phase_n;
			bit_q   <= bit_n;
			byte_q  <= byte_n;
			shift_q <= shift_n;
			data_q  <= data_n;
			cmd_q   <= cmd_n;
			nack_q  <= nack_n;
			scl_q   <= res.scl_level;
			sda_q   <= res.sda_out;
			drv_q   <= res.sda_drive;
		end
	end

	// SDA is released only while sampling the acknowledge
	`I2CDAC_ASSERT_NOW(a_release_in_ack, !drv_q, phase_q == PH_ACK_SAMPLE)
	// A released line is reported high
	`I2CDAC_ASSERT_NOW(a_release_high, !drv_q, sda_q)
	// A completed transaction leaves the engine idle
	`I2CDAC_ASSERT_NEXT(a_done_idle, step_en && res.done_res, phase_q == PH_IDLE)
	// The phase only moves on a step
	`I2CDAC_ASSERT_NEXT(a_phase_hold, !step_en, $stable(phase_q))

endmodule

// ===== hdl/i2c_dac_write_master_core.sv =====
// ----------------------------------------------------------------------------
// I2C DAC write master - top level
// Write-only I2C master for a four-channel DAC, advanced one bus phase per
// request transaction.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item per transaction: operation (tick or write request),
//   channel, code and the sampled SDA level. rsp returns exactly one result
//   per item: SCL/SDA levels, SDA drive enable, busy, done and status.
//   A write request while idle starts a bus transaction (start, address,
//   command, two data bytes, stop) unless the bus is disabled or the channel
//   is out of range, when it is rejected; every following item advances the
//   transaction by one phase. A request while busy is treated as a tick.
//   An accepted item is held in the input register, then its result in the
//   result register. Throughput: one item per cycle while rsp does not stall,
//   set by the combinational phase update between the two registers.
//   The user must write the configuration port (cfg_we, cfg_index, cfg_wdata)
//   only while the block is idle; the block itself does not enforce this.
//   Reset clears the bus to idle, drives SCL and SDA high, disables the bus
//   and sets the device address to 12.
//   When rsp stalls the result is held, one further item is taken into the
//   input register, and req then stalls until the result is taken.
// ----------------------------------------------------------------------------
module i2c_dac_write_master_core
	import i2cdac_pkg::*;
#(
	parameter int NUM_CHANNELS = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	i2cdac_stream_if.sink          req,
	i2cdac_stream_if.source        rsp
);

	logic       bus_en_q;
	logic [6:0] dev_addr_q;
	req_t       req_s1;
	logic       valid_s1;
	res_t       res_q;
	logic       rsp_valid_q;
	logic       go_s1;
	res_t       res_c;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_en_q   <= 1'b0;
			dev_addr_q <= DEV_ADDR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BUS_ENABLED:    bus_en_q   <= cfg_wdata[0];
				CFG_DEVICE_ADDRESS: dev_addr_q <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	// Advance the input stage when the result register is free
	assign go_s1     = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || go_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1 <= req.data;
		end
	end

	i2cdac_engine #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.step_en        (go_s1),
		.req            (req_s1),
		.bus_enabled    (bus_en_q),
		.device_address (dev_addr_q),
		.res            (res_c)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (go_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			res_q <= res_c;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = res_q;

endmodule
